>>> hdl/rli_pkg.sv
package rli_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int SIZE_W       = 6;
  localparam int CMD_W        = 2;
  localparam int SYM_W        = 8;
  localparam int STATUS_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_PRINT  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ELEMENT = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

endpackage

>>> hdl/rli_cmd_if.sv
interface rli_cmd_if import rli_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SIZE_W-1:0] position;
  logic [SYM_W-1:0]  symbol;

  modport source (output valid, cmd, position, symbol, input ready);
  modport sink   (input valid, cmd, position, symbol, output ready);
endinterface

>>> hdl/rli_res_if.sv
interface rli_res_if import rli_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SYM_W-1:0]    element;
  logic                last;

  modport source (output valid, status, element, last, input ready);
  modport sink   (input valid, status, element, last, output ready);
endinterface

>>> hdl/rli_ram.sv
module rli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ranked_list_insert_delete.sv
// Add and delete shift entries one step at a time, each step a read (S_SH_RD) then a
//   write (S_SH_WR) through the single-port-pair entry RAM and one index adder.
// Get: read (S_RD), then result (S_EMIT); print: min(size,32) elements, read and emitted
//   in turn. Errors (full, invalid rank, empty print) go via S_STATUS. One item at a time.
// Reset (rst_n low, synchronous) clears size, sequencer and output valid;
//   the entry RAM is not cleared.
module ranked_list_insert_delete import rli_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rli_cmd_if.sink    in_ch,
  rli_res_if.source  out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [SIZE_W-1:0] CAP_V = SIZE_W'(CAPACITY);
  localparam logic [SIZE_W-1:0] LIM_V = SIZE_W'(RESULT_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_RD,
    S_EMIT,
    S_STATUS
  } state_t;

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [SIZE_W-1:0] idx_r, idx_nxt;
  logic [SIZE_W-1:0] stop_r, stop_nxt;
  logic              up_r, up_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  status_t           stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SYM_W-1:0]  out_element_r, out_element_nxt;
  logic              out_last_r, out_last_nxt;

  logic [SIZE_W-1:0] nbr;
  logic [SIZE_W-1:0] pos;
  logic [SIZE_W-1:0] pos_m1;
  logic [SIZE_W-1:0] print_cnt;
  logic              pos_bad_rd;
  logic              pos_bad_add;
  logic              acc;
  logic              out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [SYM_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [SYM_W-1:0]  ram_rdata;

  rli_ram #(
    .WIDTH (SYM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready    = (state_r == S_IDLE);
  assign acc            = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid_r || out_ch.ready;
  assign nbr            = up_r ? (idx_r + SIZE_W'(1)) : (idx_r - SIZE_W'(1));
  assign pos            = in_ch.position;
  assign pos_m1         = pos - SIZE_W'(1);
  assign print_cnt      = (size_r < LIM_V) ? size_r : LIM_V;
  assign pos_bad_rd     = (pos == '0) || (pos > size_r);
  assign pos_bad_add    = (pos == '0) || ({1'b0, pos} > ({1'b0, size_r} + (SIZE_W+1)'(1)));

  always_comb begin
    state_nxt       = state_r;
    size_nxt        = size_r;
    idx_nxt         = idx_r;
    stop_nxt        = stop_r;
    up_nxt          = up_r;
    sym_nxt         = sym_r;
    stat_nxt        = stat_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = AW'(idx_r);
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = AW'(nbr);

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (cmd_t'(in_ch.cmd))
            CMD_ADD: begin
              if (size_r == CAP_V) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_STATUS;
              end else if (pos_bad_add) begin
                stat_nxt  = ST_INVALID;
                state_nxt = S_STATUS;
              end else begin
                idx_nxt   = size_r;
                stop_nxt  = pos_m1;
                up_nxt    = 1'b0;
                sym_nxt   = in_ch.symbol;
                state_nxt = S_SH_RD;
              end
            end
            CMD_DELETE: begin
              if (pos_bad_rd) begin
                stat_nxt  = ST_INVALID;
                state_nxt = S_STATUS;
              end else begin
                idx_nxt   = pos_m1;
                stop_nxt  = size_r - SIZE_W'(1);
                up_nxt    = 1'b1;
                state_nxt = S_SH_RD;
              end
            end
            CMD_GET: begin
              if (pos_bad_rd) begin
                stat_nxt  = ST_INVALID;
                state_nxt = S_STATUS;
              end else begin
                idx_nxt   = pos_m1;
                stop_nxt  = pos_m1;
                up_nxt    = 1'b1;
                state_nxt = S_RD;
              end
            end
            CMD_PRINT: begin
              if (size_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_STATUS;
              end else begin
                idx_nxt   = '0;
                stop_nxt  = print_cnt - SIZE_W'(1);
                up_nxt    = 1'b1;
                state_nxt = S_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SH_RD: begin
        if (idx_r == stop_r) begin
          if (up_r) begin
            size_nxt = size_r - SIZE_W'(1);
          end else begin
            ram_we    = 1'b1;
            ram_wdata = sym_r;
            size_nxt  = size_r + SIZE_W'(1);
          end
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = nbr;
        state_nxt = S_SH_RD;
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(idx_r);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_ELEMENT;
          out_element_nxt = ram_rdata;
          out_last_nxt    = (idx_r == stop_r);
          if (idx_r == stop_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = nbr;
            state_nxt = S_RD;
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = stat_r;
          out_element_nxt = '0;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    stop_r        <= stop_nxt;
    up_r          <= up_nxt;
    sym_r         <= sym_nxt;
    stat_r        <= stat_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.element = out_element_r;
  assign out_ch.last    = out_last_r;

endmodule

>>> hdl/rli_checker.sv
module rli_checker import rli_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [SYM_W-1:0]    out_element,
  input logic                out_last
);

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ELEMENT) |-> out_last)
    else $error("status result without last");

  a_status_zero_elem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ELEMENT) |-> (out_element == '0))
    else $error("status result with nonzero element");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_element) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind ranked_list_insert_delete rli_checker u_rli_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_element (out_ch.element),
  .out_last    (out_ch.last)
);
